/* design/terb_pkg.sv */
// Shared types, constants and helpers for the trigger event range builder.
package terb_pkg;

	localparam int ID_W = 48;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] MODE_RUN = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;
	localparam logic [1:0] MODE_EXIT = 2'd3;

	localparam logic [1:0] KIND_EVENT = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;
	localparam logic [1:0] KIND_EXIT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PRETRIGGER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP = 1'd1;

	typedef struct packed {
		logic [1:0] mode;
		logic [47:0] record_id;
		logic trigger;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [47:0] first_id;
		logic [47:0] final_id;
		logic last;
	} result_t;

	typedef enum logic [2:0] {
		OP_RUN_HIT,
		OP_RUN_MISS,
		OP_START,
		OP_STOP,
		OP_EXIT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [ID_W-1:0] id;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

endpackage

/* design/trigger_event_range_builder.sv */
// Top level of the trigger event range builder: front, command queue and back.
//
//  channel  | handshake                    | beat
//  ---------+------------------------------+-----------------------------------
//  item     | item_valid / item_stall      | item   (mode, record_id, trigger)
//  result   | result_valid / result_stall  | result (kind, first_id, final_id, last)
//  config   | cfg_we                       | cfg_index, cfg_data
//
// One item per cycle is accepted while item_stall is low; the back part retires one command per cycle
// unless a stalled result holds it. A stop or exit that closes an open event emits two result beats
// through the single result register, first the finished event and then the marker.
// arst_n clears the queue, event state, configuration and result valid.
// A stalled result holds the back part at the next command that emits a beat;
// the two-entry queue then fills and raises item_stall.
module trigger_event_range_builder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  terb_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output terb_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [terb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [terb_pkg::CFG_W-1:0]     cfg_data
);

	terb_pkg::cmd_beat_t push;
	terb_pkg::cmd_beat_t head;
	logic queue_full;
	logic pop;

	terb_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.queue_full (queue_full),
		.push       (push)
	);

	terb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.head   (head)
	);

	terb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	a_marker_zero_ids: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != terb_pkg::KIND_EVENT |->
			result.first_id == '0 && result.final_id == '0)
		else $error("marker beat carries nonzero ids");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != terb_pkg::KIND_EVENT |-> result.last)
		else $error("marker beat not flagged last");

	a_not_last_is_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.kind == terb_pkg::KIND_EVENT)
		else $error("non-last beat is not a finished event");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> queue_full && head.valid)
		else $error("item stalled with queue space");

endmodule

/* design/terb_front.sv */
// Front part: accepts item beats and classifies them into commands.
module terb_front (
	input  terb_pkg::item_t     item,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                queue_full,
	output terb_pkg::cmd_beat_t push
);

	terb_pkg::op_t op;

	always_comb begin
		unique case (item.mode)
			terb_pkg::MODE_RUN:   op = item.trigger ? terb_pkg::OP_RUN_HIT : terb_pkg::OP_RUN_MISS;
			terb_pkg::MODE_START: op = terb_pkg::OP_START;
			terb_pkg::MODE_STOP:  op = terb_pkg::OP_STOP;
			terb_pkg::MODE_EXIT:  op = terb_pkg::OP_EXIT;
			default:              op = terb_pkg::OP_START;
		endcase
	end

	assign item_stall = queue_full;
	assign push.valid = item_valid && !queue_full;
	assign push.cmd.op = op;
	assign push.cmd.id = item.record_id[terb_pkg::ID_W-1:0];

endmodule

/* design/terb_queue.sv */
// Short command queue between the front and back parts.
module terb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  terb_pkg::cmd_beat_t push,
	input  logic                pop,
	output logic                full,
	output terb_pkg::cmd_beat_t head
);

	terb_pkg::cmd_t mem [terb_pkg::QUEUE_DEPTH];
	logic [terb_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [terb_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [terb_pkg::QCNT_W-1:0] count_q;
	logic do_pop;

	assign full = (count_q == terb_pkg::QCNT_W'(terb_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd = mem[rd_ptr_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == terb_pkg::QPTR_W'(terb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == terb_pkg::QPTR_W'(terb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/terb_back.sv */
// Back part: event state, configuration registers and the result register.
module terb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [terb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [terb_pkg::CFG_W-1:0]  cfg_data,
	input  terb_pkg::cmd_beat_t         head,
	output logic                        pop,
	output terb_pkg::result_t           result,
	output logic                        result_valid,
	input  logic                        result_stall
);

	localparam int W = terb_pkg::ID_W;

	logic [terb_pkg::CFG_W-1:0] pretrigger_q;
	logic [terb_pkg::CFG_W-1:0] skip_q;
	logic in_event_q;
	logic span_empty_q;
	logic [W-1:0] span_first_q;
	logic [W-1:0] span_final_q;
	logic [W-1:0] event_first_q;
	logic [W-1:0] event_final_q;
	logic result_valid_q;
	terb_pkg::result_t result_q;

	logic [W+1:0] cand_wide;
	logic [W-1:0] cand;
	logic [W-1:0] pre_start;
	logic [W-1:0] span_gap;
	logic close_skip;
	logic out_free;
	logic emit;
	logic fire;
	logic hold;
	terb_pkg::result_t res_d;

	// start = max(span_final + 1 - pretrigger, span_first), clamped to the id range
	assign cand_wide = {2'b00, span_final_q} + (W+2)'(1) - {{(W+2-terb_pkg::CFG_W){1'b0}}, pretrigger_q};
	assign cand = cand_wide[W+1] ? '0 : (cand_wide[W] ? '1 : cand_wide[W-1:0]);
	assign pre_start = (cand > span_first_q) ? cand : span_first_q;

	assign span_gap = head.cmd.id - span_first_q;
	assign close_skip = span_empty_q ? (skip_q == '0) :
		((head.cmd.id < span_first_q) || (span_gap >= {{(W-terb_pkg::CFG_W){1'b0}}, skip_q}));

	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		emit = 1'b0;
		hold = 1'b0;
		res_d = '0;
		unique case (head.cmd.op) inside
			terb_pkg::OP_START: begin
				emit = 1'b1;
				res_d.kind = terb_pkg::KIND_START;
				res_d.last = 1'b1;
			end
			terb_pkg::OP_STOP, terb_pkg::OP_EXIT: begin
				emit = 1'b1;
				if (in_event_q) begin
					hold = 1'b1;
					res_d.kind = terb_pkg::KIND_EVENT;
					res_d.first_id = event_first_q;
					res_d.final_id = event_final_q;
				end else begin
					res_d.kind = (head.cmd.op == terb_pkg::OP_STOP) ?
						terb_pkg::KIND_STOP : terb_pkg::KIND_EXIT;
					res_d.last = 1'b1;
				end
			end
			terb_pkg::OP_RUN_MISS: begin
				emit = in_event_q && close_skip;
				res_d.kind = terb_pkg::KIND_EVENT;
				res_d.first_id = event_first_q;
				res_d.final_id = event_final_q;
				res_d.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign fire = head.valid && (!emit || out_free);
	assign pop = fire && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pretrigger_q <= '0;
			skip_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				terb_pkg::REG_PRETRIGGER: pretrigger_q <= cfg_data;
				terb_pkg::REG_SKIP:       skip_q <= cfg_data;
				default:                  pretrigger_q <= pretrigger_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_event_q <= 1'b0;
			span_empty_q <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				result_valid_q <= fire && emit;
			end
			if (fire) begin
				unique case (head.cmd.op) inside
					terb_pkg::OP_STOP, terb_pkg::OP_EXIT: begin
						if (in_event_q) begin
							in_event_q <= 1'b0;
						end else begin
							span_empty_q <= 1'b1;
						end
					end
					terb_pkg::OP_RUN_HIT: begin
						in_event_q <= 1'b1;
						span_empty_q <= 1'b1;
					end
					terb_pkg::OP_RUN_MISS: begin
						span_empty_q <= 1'b0;
						if (in_event_q && close_skip) begin
							in_event_q <= 1'b0;
						end
					end
					default: begin
						in_event_q <= in_event_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && emit) begin
			result_q <= res_d;
		end
		if (fire && head.cmd.op == terb_pkg::OP_RUN_HIT) begin
			if (!in_event_q) begin
				event_first_q <= span_empty_q ? head.cmd.id : pre_start;
			end
			event_final_q <= head.cmd.id;
		end
		if (fire && head.cmd.op == terb_pkg::OP_RUN_MISS) begin
			if (span_empty_q) begin
				span_first_q <= head.cmd.id;
			end
			span_final_q <= head.cmd.id;
		end
	end

	assign result = result_q;
	assign result_valid = result_valid_q;

endmodule
